// File: hw/rtl/ordval_pkg.sv
// Shared types, constants and helpers for the ordinal range record validator.
package ordval_pkg;

    localparam int ORD_W   = 25;
    localparam int TOTAL_W = 26;
    localparam int BODY_W  = 28;
    localparam int POS_W   = 5;
    localparam int FIELD_W = 32;

    localparam logic [ORD_W-1:0]  MAX_ORDINAL = 25'h100_0000;
    localparam logic [BODY_W-1:0] BODY_LIMIT  = 28'hFFF_FFFF;
    localparam logic [63:0]       MAGIC_WORD  = 64'h4C43_444F_4D31_0000;
    localparam logic [7:0]        RELEASE_ONE = 8'd1;

    // Header byte positions
    localparam logic [POS_W-1:0] POS_MAGIC_END  = 5'd7;
    localparam logic [POS_W-1:0] POS_RELEASE    = 5'd8;
    localparam logic [POS_W-1:0] POS_POINTS_END = 5'd16;
    localparam logic [POS_W-1:0] POS_RANGES_END = 5'd24;
    localparam logic [POS_W-1:0] HEADER_BYTES   = 5'd25;

    // Byte slots within one 8-byte range pair
    localparam logic [2:0] SLOT_START_END = 3'd3;
    localparam logic [2:0] SLOT_PAIR_END  = 3'd7;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TRUNCATED = 3'd1,
        ST_LENGTH    = 3'd2,
        ST_MAGIC     = 3'd3,
        ST_NONCANON  = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } in_word_t;

    typedef struct packed {
        status_t          status;
        logic [ORD_W-1:0] num_points;
        logic [ORD_W-1:0] num_ranges;
    } result_t;

    // Expected magic byte at a header position, first byte highest
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [63:0] w;
        w = MAGIC_WORD >> {~idx, 3'b000};
        return w[7:0];
    endfunction

endpackage

// File: hw/rtl/ordval_in_stage.sv
// Input register: holds one record word until the checker consumes it.
module ordval_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    input  logic                out_free,
    output logic                advance,
    output ordval_pkg::in_word_t word
);
    import ordval_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    // Advance unless a final word would land on a full result register
    assign advance  = valid_reg && (!word_reg.last || out_free);
    assign in_ready = !valid_reg || advance;
    assign word     = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on accept
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg.data <= data_byte;
            word_reg.last <= last_byte;
        end
    end

endmodule

// File: hw/rtl/ordval_checker.sv
// Record checker: header decode, range pair checks and the final verdict.
module ordval_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  ordval_pkg::in_word_t word,
    output logic                 res_valid,
    output ordval_pkg::result_t  result
);
    import ordval_pkg::*;

    logic [POS_W-1:0]   pos_reg,       pos_next;
    logic [FIELD_W-1:0] field_reg,     field_next;
    logic               hi_reg,        hi_next;
    logic               magic_bad_reg, magic_bad_next;
    logic [ORD_W-1:0]   points_reg,    points_next;
    logic [ORD_W-1:0]   ranges_reg,    ranges_next;
    logic [BODY_W-1:0]  body_reg,      body_next;
    logic [ORD_W-1:0]   start_reg,     start_next;
    logic [ORD_W-1:0]   prev_end_reg,  prev_end_next;
    logic               have_prev_reg, have_prev_next;
    logic [TOTAL_W-1:0] total_reg,     total_next;
    status_t            err_reg,       err_next;

    logic [FIELD_W-1:0] shifted;
    logic               carry_hi;
    logic [BODY_W-1:0]  pair_limit;
    logic [ORD_W-1:0]   other_limit;
    logic [ORD_W-1:0]   most_ranges;
    logic [ORD_W-1:0]   span;
    logic               pair_bad;
    status_t            verdict;

    always_comb
    begin
        shifted     = {field_reg[FIELD_W-9:0], word.data};
        carry_hi    = hi_reg | (|field_reg[FIELD_W-1:FIELD_W-8]);
        pair_limit  = {ranges_reg, 3'b000};
        other_limit = MAX_ORDINAL - points_reg + ORD_W'(1);
        most_ranges = (other_limit < points_reg) ? other_limit : points_reg;
        span        = shifted[ORD_W-1:0] - start_reg;
        pair_bad    = ({7'b0, start_reg} >= shifted)
                      || (shifted > FIELD_W'(MAX_ORDINAL))
                      || (have_prev_reg && (start_reg <= prev_end_reg));

        pos_next       = pos_reg;
        field_next     = field_reg;
        hi_next        = hi_reg;
        magic_bad_next = magic_bad_reg;
        points_next    = points_reg;
        ranges_next    = ranges_reg;
        body_next      = body_reg;
        start_next     = start_reg;
        prev_end_next  = prev_end_reg;
        have_prev_next = have_prev_reg;
        total_next     = total_reg;
        err_next       = err_reg;

        if (pos_reg < HEADER_BYTES)
        begin
            // Header: decode fields until the first error, count bytes always
            pos_next = pos_reg + POS_W'(1);
            if (err_reg == ST_OK)
            begin
                field_next = shifted;
                hi_next    = carry_hi;
                case (pos_reg)
                    POS_MAGIC_END:
                    begin
                        if (magic_bad_reg || (word.data != magic_byte(pos_reg[2:0])))
                        begin
                            err_next = ST_MAGIC;
                        end
                        field_next = '0;
                        hi_next    = 1'b0;
                    end
                    POS_RELEASE:
                    begin
                        if (word.data != RELEASE_ONE)
                        begin
                            err_next = ST_NONCANON;
                        end
                        field_next = '0;
                        hi_next    = 1'b0;
                    end
                    POS_POINTS_END:
                    begin
                        if (carry_hi || (shifted == '0) || (shifted > FIELD_W'(MAX_ORDINAL)))
                        begin
                            err_next = ST_NONCANON;
                        end
                        else
                        begin
                            points_next = shifted[ORD_W-1:0];
                        end
                        field_next = '0;
                        hi_next    = 1'b0;
                    end
                    POS_RANGES_END:
                    begin
                        if (carry_hi || (shifted == '0) || (shifted > FIELD_W'(most_ranges)))
                        begin
                            err_next = ST_LENGTH;
                        end
                        else
                        begin
                            ranges_next = shifted[ORD_W-1:0];
                        end
                        field_next = '0;
                        hi_next    = 1'b0;
                    end
                    default:
                    begin
                        if (pos_reg < POS_MAGIC_END)
                        begin
                            magic_bad_next = magic_bad_reg
                                             | (word.data != magic_byte(pos_reg[2:0]));
                        end
                    end
                endcase
            end
        end
        else if (ranges_reg != '0)
        begin
            // Body: assemble start/end words while error-free and within the declared length
            if ((err_reg == ST_OK) && (body_reg < pair_limit))
            begin
                field_next = shifted;
                case (body_reg[2:0])
                    SLOT_START_END:
                    begin
                        start_next = (shifted > FIELD_W'(MAX_ORDINAL))
                                     ? MAX_ORDINAL + ORD_W'(1) : shifted[ORD_W-1:0];
                        field_next = '0;
                    end
                    SLOT_PAIR_END:
                    begin
                        field_next = '0;
                        if (pair_bad)
                        begin
                            err_next = ST_NONCANON;
                        end
                        else
                        begin
                            total_next     = total_reg + {1'b0, span};
                            prev_end_next  = shifted[ORD_W-1:0];
                            have_prev_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            // Saturate the body byte count
            if (body_reg != BODY_LIMIT)
            begin
                body_next = body_reg + BODY_W'(1);
            end
        end

        // Verdict from the state after this word; length outranks range errors
        if (ranges_next != '0)
        begin
            if (body_next != {ranges_next, 3'b000})
            begin
                verdict = ST_LENGTH;
            end
            else if (err_next != ST_OK)
            begin
                verdict = err_next;
            end
            else if (total_next != {1'b0, points_next})
            begin
                verdict = ST_NONCANON;
            end
            else
            begin
                verdict = ST_OK;
            end
        end
        else if (err_next != ST_OK)
        begin
            verdict = err_next;
        end
        else
        begin
            verdict = ST_TRUNCATED;
        end
    end

    assign res_valid         = fire && word.last;
    assign result.status     = verdict;
    assign result.num_points = points_next;
    assign result.num_ranges = ranges_next;

    // Advance the record state; drop it all after the final word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            field_reg     <= '0;
            hi_reg        <= 1'b0;
            magic_bad_reg <= 1'b0;
            points_reg    <= '0;
            ranges_reg    <= '0;
            body_reg      <= '0;
            start_reg     <= '0;
            prev_end_reg  <= '0;
            have_prev_reg <= 1'b0;
            total_reg     <= '0;
            err_reg       <= ST_OK;
        end
        else if (fire)
        begin
            if (word.last)
            begin
                pos_reg       <= '0;
                field_reg     <= '0;
                hi_reg        <= 1'b0;
                magic_bad_reg <= 1'b0;
                points_reg    <= '0;
                ranges_reg    <= '0;
                body_reg      <= '0;
                start_reg     <= '0;
                prev_end_reg  <= '0;
                have_prev_reg <= 1'b0;
                total_reg     <= '0;
                err_reg       <= ST_OK;
            end
            else
            begin
                pos_reg       <= pos_next;
                field_reg     <= field_next;
                hi_reg        <= hi_next;
                magic_bad_reg <= magic_bad_next;
                points_reg    <= points_next;
                ranges_reg    <= ranges_next;
                body_reg      <= body_next;
                start_reg     <= start_next;
                prev_end_reg  <= prev_end_next;
                have_prev_reg <= have_prev_next;
                total_reg     <= total_next;
                err_reg       <= err_next;
            end
        end
    end

endmodule

// File: hw/rtl/ordval_out_stage.sv
// Result register: holds one verdict word until the consumer takes it.
module ordval_out_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        res_valid,
    input  ordval_pkg::result_t         result,
    output logic                        out_free,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  status,
    output logic [ordval_pkg::ORD_W-1:0] num_points,
    output logic [ordval_pkg::ORD_W-1:0] num_ranges
);
    import ordval_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_free   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign status     = result_reg.status;
    assign num_points = result_reg.num_points;
    assign num_ranges = result_reg.num_ranges;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load a fresh verdict
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            result_reg <= result;
        end
    end

endmodule

// File: hw/rtl/ordinal_range_record_validator.sv
// Top level of the ordinal range record validator.
//
//   channel  signals                                  direction
//   in       in_valid, in_ready, data_byte, last_byte  record bytes in, one per word
//   out      out_valid, out_ready, status,             one verdict word per record,
//            num_points, num_ranges                    after the final byte
//
// Takes one byte per cycle unless a final byte is held for the result register; the checker is
// combinational between the input register and the result register.
// out_valid rises once the final byte has passed from the input register into the result register.
// Reset (rst_n low) clears all record state, so the next byte starts a record.
// While a verdict waits on out_ready, non-final bytes keep flowing; a final
// byte is held in the input register until the result register frees up.
module ordinal_range_record_validator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  data_byte,
    input  logic                        last_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  status,
    output logic [ordval_pkg::ORD_W-1:0] num_points,
    output logic [ordval_pkg::ORD_W-1:0] num_ranges
);
    import ordval_pkg::*;

    logic     out_free;
    logic     advance;
    in_word_t word;
    logic     res_valid;
    result_t  result;

    ordval_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_free  (out_free),
        .advance   (advance),
        .word      (word)
    );

    ordval_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .word      (word),
        .res_valid (res_valid),
        .result    (result)
    );

    ordval_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .result     (result),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .num_points (num_points),
        .num_ranges (num_ranges)
    );

    // A verdict never lands on an untaken one
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_free)
        else $error("verdict loaded while result register full");

    // Truncated only when no range count was accepted
    a_trunc_no_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_TRUNCATED)) |-> (num_ranges == '0))
        else $error("truncated verdict with a range count");

    // An accepted range count never exceeds the point count
    a_ranges_le_points: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (num_ranges <= num_points))
        else $error("range count above point count");

    // A passing record carries both counts
    a_ok_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_OK)) |-> ((num_points != '0) && (num_ranges != '0)))
        else $error("ok verdict with a zero count");

endmodule
